@@ hdl/sawcf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the stop-and-wait chunk fetch unit.
// No dependencies; imported by every module of the block.
package sawcf_pkg;

   // Default chunk size in bytes
   localparam int CHUNK_BYTES_DEF = 1024;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   // Configuration register indexes
   localparam logic [2:0] CSR_FILE_ID       = 3'd0;
   localparam logic [2:0] CSR_META_WINDOW   = 3'd1;
   localparam logic [2:0] CSR_DATA_WINDOW   = 3'd2;
   localparam logic [2:0] CSR_META_TRY_LIM  = 3'd3;
   localparam logic [2:0] CSR_DATA_RETRY_LIM = 3'd4;
   localparam logic [2:0] CSR_META_CODE     = 3'd5;
   localparam logic [2:0] CSR_DATA_CODE     = 3'd6;

   // Configuration reset values
   localparam logic [7:0] FILE_ID_RST        = 8'd0;
   localparam logic [7:0] META_WINDOW_RST    = 8'd100;
   localparam logic [7:0] DATA_WINDOW_RST    = 8'd200;
   localparam logic [5:0] META_TRY_LIM_RST   = 6'd10;
   localparam logic [5:0] DATA_RETRY_LIM_RST = 6'd50;
   localparam logic [7:0] META_CODE_RST      = 8'd2;
   localparam logic [7:0] DATA_CODE_RST      = 8'd4;

   // Request types
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_POLL  = 2'd1;
   localparam logic [1:0] REQ_PKT   = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_MREQ  = 3'd0;
   localparam logic [2:0] KIND_DREQ  = 3'd1;
   localparam logic [2:0] KIND_META  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_DONE  = 3'd4;
   localparam logic [2:0] KIND_FAIL  = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  msg_type;
      logic [7:0]  pkt_file;
      logic [31:0] pkt_size;
      logic [31:0] pkt_chunk_count;
      logic [31:0] pkt_index;
      logic [15:0] pkt_data_len;
   } sawcf_req_type;

   typedef struct packed {
      logic [2:0]  res_kind;
      logic [31:0] chunk_index;
      logic [31:0] write_offset;
      logic [15:0] write_length;
      logic [31:0] file_size_out;
      logic [31:0] chunk_count_out;
      logic        last;
   } sawcf_rsp_type;

   typedef struct packed {
      logic [7:0] file_id;
      logic [7:0] meta_window;
      logic [7:0] data_window;
      logic [5:0] meta_try_limit;
      logic [5:0] data_retry_limit;
      logic [7:0] meta_resp_code;
      logic [7:0] data_resp_code;
   } sawcf_cfg_type;

   // Results of one transaction: up to two, in order
   typedef struct packed {
      logic [1:0]    cnt;
      sawcf_rsp_type res0;
      sawcf_rsp_type res1;
   } sawcf_step_out_type;

   // Queue status seen by the top level
   typedef struct packed {
      logic                 space_ok;
      logic [RSP_LVL_W-1:0] level;
   } sawcf_q_stat_type;

endpackage

@@ hdl/sawcf_step.sv @@
`timescale 1ns / 1ps
// Fetch protocol state and the per-transaction decision logic.
// Depends on sawcf_pkg.
module sawcf_step
   import sawcf_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  sawcf_req_type      item,
   input  sawcf_cfg_type      cfg,
   input  logic               fire,
   output sawcf_step_out_type out
);

   localparam int OFFSET_W = 32 + $clog2(CHUNK_BYTES + 1);
   localparam logic [OFFSET_W-1:0] CHUNK_STEP = OFFSET_W'(CHUNK_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_META = 3'd1,
      PH_DATA = 3'd2,
      PH_DONE = 3'd3,
      PH_FAIL = 3'd4
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [31:0]           size_ff, size_in;
   logic [31:0]           chunks_ff, chunks_in;
   logic [31:0]           chunk_ff, chunk_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [7:0]            wait_ff, wait_in;
   logic [5:0]            retry_ff, retry_in;

   logic                  pkt;
   logic [7:0]            wait_next;
   logic [5:0]            retry_next;
   logic [31:0]           chunk_next;
   logic                  fits;

   function automatic sawcf_rsp_type make_rsp(
      input logic [2:0]  kind,
      input logic [31:0] idx,
      input logic [31:0] off,
      input logic [15:0] len,
      input logic [31:0] sz,
      input logic [31:0] cnt,
      input logic        lst
   );
      sawcf_rsp_type r;
      r.res_kind        = kind;
      r.chunk_index     = idx;
      r.write_offset    = off;
      r.write_length    = len;
      r.file_size_out   = sz;
      r.chunk_count_out = cnt;
      r.last            = lst;
      return r;
   endfunction

   // Shared terms of the decision
   assign pkt        = (item.req_type == REQ_PKT) && (item.pkt_file == cfg.file_id);
   assign wait_next  = wait_ff + 8'd1;
   assign retry_next = retry_ff + 6'd1;
   assign chunk_next = chunk_ff + 32'd1;
   assign fits = ({1'b0, offset_ff} + (OFFSET_W + 1)'(item.pkt_data_len))
                 <= (OFFSET_W + 1)'(size_ff);

   // Decide results and next state for the held transaction
   always_comb begin
      phase_in  = phase_ff;
      size_in   = size_ff;
      chunks_in = chunks_ff;
      chunk_in  = chunk_ff;
      offset_in = offset_ff;
      wait_in   = wait_ff;
      retry_in  = retry_ff;
      out.cnt   = 2'd0;
      out.res0  = make_rsp(KIND_MREQ, '0, '0, '0, '0, '0, 1'b0);
      out.res1  = make_rsp(KIND_MREQ, '0, '0, '0, '0, '0, 1'b0);

      if (item.req_type == REQ_START) begin
         phase_in  = PH_META;
         size_in   = '0;
         chunks_in = '0;
         chunk_in  = '0;
         offset_in = '0;
         wait_in   = '0;
         retry_in  = '0;
         out.cnt   = 2'd1;
         out.res0  = make_rsp(KIND_MREQ, '0, '0, '0, '0, '0, 1'b1);
      end else begin
         case (phase_ff)
            PH_META: begin
               if (pkt && item.msg_type == cfg.meta_resp_code) begin
                  size_in   = item.pkt_size;
                  chunks_in = item.pkt_chunk_count;
                  chunk_in  = '0;
                  offset_in = '0;
                  wait_in   = '0;
                  retry_in  = '0;
                  out.cnt   = 2'd2;
                  out.res0  = make_rsp(KIND_META, '0, '0, '0, item.pkt_size,
                                       item.pkt_chunk_count, 1'b0);
                  if (item.pkt_chunk_count == '0) begin
                     phase_in = PH_DONE;
                     out.res1 = make_rsp(KIND_DONE, '0, '0, '0, item.pkt_size,
                                         item.pkt_chunk_count, 1'b1);
                  end else begin
                     phase_in = PH_DATA;
                     out.res1 = make_rsp(KIND_DREQ, '0, '0, '0, '0, '0, 1'b1);
                  end
               end else if (wait_next >= cfg.meta_window) begin
                  // window expired: resend or give up
                  wait_in  = '0;
                  retry_in = retry_next;
                  out.cnt  = 2'd1;
                  if (retry_next >= cfg.meta_try_limit) begin
                     phase_in = PH_FAIL;
                     out.res0 = make_rsp(KIND_FAIL, '0, '0, '0, '0, '0, 1'b1);
                  end else begin
                     out.res0 = make_rsp(KIND_MREQ, '0, '0, '0, '0, '0, 1'b1);
                  end
               end else begin
                  wait_in = wait_next;
               end
            end
            PH_DATA: begin
               if (pkt && item.msg_type == cfg.data_resp_code &&
                   item.pkt_index == chunk_ff) begin
                  wait_in   = '0;
                  retry_in  = '0;
                  chunk_in  = chunk_next;
                  offset_in = (chunk_next == '0) ? '0 : offset_ff + CHUNK_STEP;
                  if (chunk_next >= chunks_ff) begin
                     phase_in = PH_DONE;
                     out.res1 = make_rsp(KIND_DONE, '0, '0, '0, size_ff,
                                         chunks_ff, 1'b1);
                  end else begin
                     out.res1 = make_rsp(KIND_DREQ, chunk_next, '0, '0, '0, '0,
                                         1'b1);
                  end
                  // drop the write when it would pass the file size
                  if (fits) begin
                     out.cnt  = 2'd2;
                     out.res0 = make_rsp(KIND_WRITE, chunk_ff, offset_ff[31:0],
                                         item.pkt_data_len, '0, '0, 1'b0);
                  end else begin
                     out.cnt  = 2'd1;
                     out.res0 = out.res1;
                  end
               end else if (wait_next >= cfg.data_window) begin
                  wait_in = '0;
                  out.cnt = 2'd1;
                  if (retry_ff >= cfg.data_retry_limit) begin
                     phase_in = PH_FAIL;
                     out.res0 = make_rsp(KIND_FAIL, '0, '0, '0, '0, '0, 1'b1);
                  end else begin
                     retry_in = retry_next;
                     out.res0 = make_rsp(KIND_DREQ, chunk_ff, '0, '0, '0, '0,
                                         1'b1);
                  end
               end else begin
                  wait_in = wait_next;
               end
            end
            default: begin
               // idle, done or failed: ignore polls and packets
            end
         endcase
      end
   end

   // Hold state; advance only when the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         size_ff   <= '0;
         chunks_ff <= '0;
         chunk_ff  <= '0;
         offset_ff <= '0;
         wait_ff   <= '0;
         retry_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         size_ff   <= size_in;
         chunks_ff <= chunks_in;
         chunk_ff  <= chunk_in;
         offset_ff <= offset_in;
         wait_ff   <= wait_in;
         retry_ff  <= retry_in;
      end
   end

endmodule

@@ hdl/sawcf_rsp_fifo.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one while rsp_ready is high.
// Depends on sawcf_pkg.
module sawcf_rsp_fifo
   import sawcf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       wr_cnt,
   input  sawcf_rsp_type    wr_data0,
   input  sawcf_rsp_type    wr_data1,
   output sawcf_q_stat_type stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sawcf_rsp_type    rsp_data
);

   sawcf_rsp_type        mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0] level_ff, level_in;
   logic [RSP_PTR_W-1:0] wr_ptr_nx;
   logic                 pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign wr_ptr_nx = wr_ptr_ff + RSP_PTR_W'(1);

   assign stat.level    = level_ff;
   assign stat.space_ok = (level_ff <= RSP_LVL_W'(RSP_DEPTH - 2));

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(wr_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + RSP_LVL_W'(wr_cnt) - RSP_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store entries in order
   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_cnt == 2'd2) begin
         mem_ff[wr_ptr_nx] <= wr_data1;
      end
   end

endmodule

@@ hdl/stop_and_wait_chunk_fetch_unit.sv @@
`timescale 1ns / 1ps
// Top level of the stop-and-wait chunk fetch unit: input register,
// configuration registers, step logic and result queue. Depends on sawcf_pkg.
//
//   channel  ports              direction  carries
//   req      req_valid/ready    in         sawcf_req_type transaction
//   rsp      rsp_valid/ready    out        sawcf_rsp_type result
//   csr      csr_valid/ready    in         3-bit register index, 8-bit data
//
// A taken transaction waits in the input register, is decided there and is
// written to the result queue when it is consumed, which a queue short of
// room can hold off; the queue then offers its results in order.
// A new transaction is taken every cycle while the four-entry result queue
// has room for two more results; rsp stalls hold the queue, then req.
// Reset is synchronous and needs no clearing pass; csr is always ready.
module stop_and_wait_chunk_fetch_unit
   import sawcf_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  sawcf_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output sawcf_rsp_type rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [7:0]    csr_data
);

   sawcf_req_type      in_ff, in_in;
   logic               in_valid_ff, in_valid_in;
   sawcf_cfg_type      cfg_ff, cfg_in;
   sawcf_step_out_type step_out;
   sawcf_q_stat_type   q_stat;
   logic               consume;
   logic [1:0]         wr_cnt;

   assign csr_ready = 1'b1;
   assign consume   = in_valid_ff && q_stat.space_ok;
   assign req_ready = !in_valid_ff || consume;
   assign wr_cnt    = consume ? step_out.cnt : 2'd0;

   // Load a new transaction or drop the one just decided
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_in       = req_data;
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ff <= in_in;
   end

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FILE_ID:        cfg_in.file_id          = csr_data;
            CSR_META_WINDOW:    cfg_in.meta_window      = csr_data;
            CSR_DATA_WINDOW:    cfg_in.data_window      = csr_data;
            CSR_META_TRY_LIM:   cfg_in.meta_try_limit   = csr_data[5:0];
            CSR_DATA_RETRY_LIM: cfg_in.data_retry_limit = csr_data[5:0];
            CSR_META_CODE:      cfg_in.meta_resp_code   = csr_data;
            CSR_DATA_CODE:      cfg_in.data_resp_code   = csr_data;
            default: begin
               // unmapped index: ignore
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_id          <= FILE_ID_RST;
         cfg_ff.meta_window      <= META_WINDOW_RST;
         cfg_ff.data_window      <= DATA_WINDOW_RST;
         cfg_ff.meta_try_limit   <= META_TRY_LIM_RST;
         cfg_ff.data_retry_limit <= DATA_RETRY_LIM_RST;
         cfg_ff.meta_resp_code   <= META_CODE_RST;
         cfg_ff.data_resp_code   <= DATA_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sawcf_step #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_step (
      .clock (clock),
      .reset (reset),
      .item  (in_ff),
      .cfg   (cfg_ff),
      .fire  (consume),
      .out   (step_out)
   );

   sawcf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_cnt    (wr_cnt),
      .wr_data0  (step_out.res0),
      .wr_data1  (step_out.res1),
      .stat      (q_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // Queue never overfills
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.level <= RSP_LVL_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   // A held transaction is not lost while the queue is short of room
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff)
      else $error("pending transaction dropped");

   // Two results: only the second one closes the transaction
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      consume && step_out.cnt == 2'd2 |-> step_out.res1.last && !step_out.res0.last)
      else $error("last flag misplaced");

   // A start always yields exactly one result
   a_start_one: assert property (@(posedge clock) disable iff (reset)
      consume && in_ff.req_type == REQ_START |-> step_out.cnt == 2'd1)
      else $error("start produced wrong result count");
`endif

endmodule
